>>> rtl/core/apf_pkg.sv
// Package for the address pool FIFO: command and status codes, record layout.
// No dependencies; used by the channel interfaces and the top level.
package apf_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FROZEN = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [1:0] t_status;

    // One table entry: queued flag travels with the pair so no per-entry flops are needed.
    typedef struct packed {
        logic        queued;
        logic [31:0] ip;
        logic [31:0] mask;
    } t_record;

endpackage

>>> rtl/core/apf_ifs.sv
// Valid/ready channel interfaces for the address pool FIFO.
// Depends on apf_pkg for the status type.
interface apf_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] addr_ip;
    logic [31:0] addr_mask;

    modport source (output valid, output command, output addr_ip, output addr_mask,
                    input ready);
    modport sink   (input valid, input command, input addr_ip, input addr_mask,
                    output ready);
endinterface

interface apf_res_if;
    logic              valid;
    logic              ready;
    apf_pkg::t_status  status;
    logic [31:0]       out_ip;
    logic [31:0]       out_mask;

    modport source (output valid, output status, output out_ip, output out_mask,
                    input ready);
    modport sink   (input valid, input status, input out_ip, input out_mask,
                    output ready);
endinterface

>>> rtl/core/apf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/address_pool_fifo.sv
// Address pool FIFO: a push scans the record table one entry per cycle through a single
// compare unit, from index 0 up to the pair or to the last of the record_count entries;
// a new or rejected pair then ends in S_MISS, directly when the table is empty. A pop
// reads the order ring and then the record RAM, and skips both reads when the queue is
// empty. The input is not ready while an item is being worked on; a finished result
// waits in an output register, so the next item may be accepted before it is taken.
// Depends on apf_pkg, apf_ifs and apf_ram; the record table and the ring are RAMs, no
// clearing pass is needed after reset.
module address_pool_fifo #(
    parameter int POOL_SIZE = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_wr_en,
    input  logic   i_cfg_wr_data,
    apf_cmd_if.sink   i_cmd,
    apf_res_if.source o_res
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int REC_W = $bits(apf_pkg::t_record);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_MISS    = 3'd2;
    localparam logic [2:0] S_POP_IDX = 3'd3;
    localparam logic [2:0] S_POP_REC = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SIZE - 1);

    // control state
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_rec_count, n_rec_count;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_ring_len, n_ring_len;
    logic             r_frozen;
    logic             r_out_valid, n_out_valid;

    // payload
    logic [31:0]       r_ip, n_ip;
    logic [31:0]       r_mask, n_mask;
    apf_pkg::t_status  r_pstatus, n_pstatus;
    logic [31:0]       r_pip, n_pip;
    logic [31:0]       r_pmask, n_pmask;
    apf_pkg::t_status  r_out_status, n_out_status;
    logic [31:0]       r_out_ip, n_out_ip;
    logic [31:0]       r_out_mask, n_out_mask;

    // RAM ports
    logic             rec_we;
    logic [IDX_W-1:0] rec_waddr, rec_raddr;
    apf_pkg::t_record rec_wdata, rec_rdata;
    logic             ring_we;
    logic [IDX_W-1:0] ring_wdata, ring_rdata;

    logic             accept;
    logic             hit;
    logic             scan_last;
    logic [IDX_W-1:0] tail_next, head_next;

    apf_ram #(.WIDTH(REC_W), .DEPTH(POOL_SIZE)) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rec_we),
        .i_wr_addr (rec_waddr),
        .i_wr_data (rec_wdata),
        .i_rd_addr (rec_raddr),
        .o_rd_data (rec_rdata)
    );

    apf_ram #(.WIDTH(IDX_W), .DEPTH(POOL_SIZE)) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_wr_addr (r_tail),
        .i_wr_data (ring_wdata),
        .i_rd_addr (r_head),
        .o_rd_data (ring_rdata)
    );

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_out_status;
    assign o_res.out_ip = r_out_ip;
    assign o_res.out_mask = r_out_mask;

    assign hit       = (rec_rdata.ip == r_ip) && (rec_rdata.mask == r_mask);
    assign scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_rec_count);
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rec_count  = r_rec_count;
        n_head       = r_head;
        n_tail       = r_tail;
        n_ring_len   = r_ring_len;
        n_out_valid  = r_out_valid;
        n_ip         = r_ip;
        n_mask       = r_mask;
        n_pstatus    = r_pstatus;
        n_pip        = r_pip;
        n_pmask      = r_pmask;
        n_out_status = r_out_status;
        n_out_ip     = r_out_ip;
        n_out_mask   = r_out_mask;
        rec_we       = 1'b0;
        rec_waddr    = r_idx;
        rec_wdata    = '{queued: 1'b1, ip: r_ip, mask: r_mask};
        rec_raddr    = r_idx;
        ring_we      = 1'b0;
        ring_wdata   = r_idx;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                rec_raddr = '0;
                if (accept) begin
                    n_ip      = i_cmd.addr_ip;
                    n_mask    = i_cmd.addr_mask;
                    n_idx     = '0;
                    n_pstatus = apf_pkg::ST_OK;
                    n_pip     = '0;
                    n_pmask   = '0;
                    if (i_cmd.command == apf_pkg::CMD_PUSH) begin
                        n_state = (r_rec_count == '0) ? S_MISS : S_SCAN;
                    end else if (r_ring_len == '0) begin
                        n_pstatus = apf_pkg::ST_EMPTY;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_POP_IDX;
                    end
                end
            end
            S_SCAN: begin
                // prefetch the next entry; read data belongs to r_idx
                rec_raddr = r_idx + IDX_W'(1);
                if (hit) begin
                    n_state = S_DONE;
                    if (!rec_rdata.queued) begin
                        rec_we     = 1'b1;
                        ring_we    = 1'b1;
                        n_tail     = tail_next;
                        n_ring_len = r_ring_len + CNT_W'(1);
                    end
                end else if (scan_last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_MISS: begin
                n_state = S_DONE;
                if (r_frozen) begin
                    n_pstatus = apf_pkg::ST_FROZEN;
                end else if (r_rec_count == CNT_W'(POOL_SIZE)) begin
                    n_pstatus = apf_pkg::ST_FULL;
                end else begin
                    // append new record and queue it
                    rec_we      = 1'b1;
                    rec_waddr   = r_rec_count[IDX_W-1:0];
                    ring_we     = 1'b1;
                    ring_wdata  = r_rec_count[IDX_W-1:0];
                    n_rec_count = r_rec_count + CNT_W'(1);
                    n_tail      = tail_next;
                    n_ring_len  = r_ring_len + CNT_W'(1);
                end
            end
            S_POP_IDX: begin
                rec_raddr  = ring_rdata;
                n_idx      = ring_rdata;
                n_head     = head_next;
                n_ring_len = r_ring_len - CNT_W'(1);
                n_state    = S_POP_REC;
            end
            S_POP_REC: begin
                // write back with the queued flag dropped
                rec_we    = 1'b1;
                rec_wdata = '{queued: 1'b0, ip: rec_rdata.ip, mask: rec_rdata.mask};
                n_pip     = rec_rdata.ip;
                n_pmask   = rec_rdata.mask;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pstatus;
                    n_out_ip     = r_pip;
                    n_out_mask   = r_pmask;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_rec_count <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_ring_len  <= '0;
            r_frozen    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_rec_count <= n_rec_count;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_ring_len  <= n_ring_len;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_frozen <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip         <= n_ip;
        r_mask       <= n_mask;
        r_pstatus    <= n_pstatus;
        r_pip        <= n_pip;
        r_pmask      <= n_pmask;
        r_out_status <= n_out_status;
        r_out_ip     <= n_out_ip;
        r_out_mask   <= n_out_mask;
    end

    // Each record is queued at most once, so the ring never outgrows the table.
    a_ring_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_len <= r_rec_count)
        else $error("ring length exceeds record count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_count <= CNT_W'(POOL_SIZE))
        else $error("record count exceeds pool size");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_rec_count >= $past(r_rec_count))
        else $error("record count decreased");

    a_fail_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != apf_pkg::ST_OK) |->
            (r_out_ip == '0 && r_out_mask == '0))
        else $error("failed result carries a payload");

endmodule
